/* src/cft_pkg.sv */
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Limits, character codes and shared types for the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cft_pkg;

   // Limits of one row.
   localparam int MAX_FIELD_CHARS = 256;
   localparam int MAX_ROW_FIELDS  = 64;

   // Widths of the state counters follow from the limits.
   localparam int LEN_W = $clog2(MAX_FIELD_CHARS);
   localparam int CNT_W = $clog2(MAX_ROW_FIELDS + 1);

   // Fixed widths of the result fields.
   localparam int BYTE_W = 8;
   localparam int FNUM_W = 6;
   localparam int POS_W  = 8;

   localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(MAX_FIELD_CHARS - 1);
   localparam logic [CNT_W-1:0]  ROW_LIMIT  = CNT_W'(MAX_ROW_FIELDS);
   localparam logic [FNUM_W-1:0] LAST_FIELD = FNUM_W'(MAX_ROW_FIELDS - 1);

   // Character codes.
   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

   // Event kinds.
   localparam logic KIND_CHAR      = 1'b0;
   localparam logic KIND_FIELD_END = 1'b1;

   typedef struct packed {
      logic             quoted_mode;
      logic             quote_pending;
      logic [LEN_W-1:0] field_length;
      logic [CNT_W-1:0] field_counter;
      logic             line_finished;
      logic             field_overflow;
   } parse_state_type;

   // After reset the parser waits for a line start.
   localparam parse_state_type STATE_RESET = '{
      quoted_mode:    1'b0,
      quote_pending:  1'b0,
      field_length:   '0,
      field_counter:  '0,
      line_finished:  1'b1,
      field_overflow: 1'b0
   };

   typedef struct packed {
      logic              valid;
      logic              event_kind;
      logic [BYTE_W-1:0] out_byte;
      logic [FNUM_W-1:0] field_number;
      logic [POS_W-1:0]  char_position;
      logic              row_end;
      logic              too_many_fields;
   } result_type;

endpackage

`default_nettype wire

/* src/csv_field_tokenizer.sv */
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Splits a byte stream of CSV lines into field characters and field ends.
// ----------------------------------------------------------------------------
// A result word is registered and appears in the cycle after its byte is taken.
// Throughput: one byte per cycle while the output word is not stalled; the
// parse step is a single combinational pass between the parse state registers
// and the output register. Reset: parse state clears and the block waits for
// a line start; the output register is emptied.
`default_nettype none

module csv_field_tokenizer (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire                          req_line_start,
   input  wire  [cft_pkg::BYTE_W-1:0]   req_char_byte,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_event_kind,
   output logic [cft_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic [cft_pkg::FNUM_W-1:0]   rsp_field_number,
   output logic [cft_pkg::POS_W-1:0]    rsp_char_position,
   output logic                         rsp_row_end,
   output logic                         rsp_too_many_fields
);

   cft_pkg::parse_state_type state_ff;
   cft_pkg::parse_state_type state_in;
   cft_pkg::result_type      step_result;
   cft_pkg::result_type      rsp_ff;
   cft_pkg::result_type      rsp_in;
   logic                     req_fire;

   cft_parser u_parser (
      .cur_state  (state_ff),
      .line_start (req_line_start),
      .char_byte  (req_char_byte),
      .next_state (state_in),
      .result     (step_result)
   );

   // The output register frees up in the same cycle its word is taken.
   assign req_ready = !rsp_ff.valid || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      rsp_in = rsp_ff;
      if (req_fire) begin
         rsp_in = step_result;
      end else if (rsp_ready) begin
         rsp_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cft_pkg::STATE_RESET;
         rsp_ff.valid <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.event_kind      <= rsp_in.event_kind;
      rsp_ff.out_byte        <= rsp_in.out_byte;
      rsp_ff.field_number    <= rsp_in.field_number;
      rsp_ff.char_position   <= rsp_in.char_position;
      rsp_ff.row_end         <= rsp_in.row_end;
      rsp_ff.too_many_fields <= rsp_in.too_many_fields;
   end

   assign rsp_valid           = rsp_ff.valid;
   assign rsp_event_kind      = rsp_ff.event_kind;
   assign rsp_out_byte        = rsp_ff.out_byte;
   assign rsp_field_number    = rsp_ff.field_number;
   assign rsp_char_position   = rsp_ff.char_position;
   assign rsp_row_end         = rsp_ff.row_end;
   assign rsp_too_many_fields = rsp_ff.too_many_fields;

   // Bytes between a row end and the next line start never give a word.
   a_idle_bytes_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && state_ff.line_finished && !req_line_start |=> !rsp_valid)
      else $error("word produced for a byte outside a line");

   a_pending_in_quotes: assert property (@(posedge clock) disable iff (reset)
      state_ff.quote_pending |-> state_ff.quoted_mode)
      else $error("pending quote outside quoted mode");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.field_length <= cft_pkg::LEN_LIMIT &&
      state_ff.field_counter <= cft_pkg::ROW_LIMIT)
      else $error("field length or field count beyond its limit");

   a_row_end_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_end |-> rsp_event_kind == cft_pkg::KIND_FIELD_END)
      else $error("row end flagged on a character word");

endmodule

`default_nettype wire

/* src/cft_parser.sv */
// ----------------------------------------------------------------------------
// CSV field tokenizer parse step
// Computes the next parse state and the optional result for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cft_parser (
   input  var cft_pkg::parse_state_type  cur_state,
   input  wire                           line_start,
   input  wire [cft_pkg::BYTE_W-1:0]     char_byte,
   output cft_pkg::parse_state_type      next_state,
   output cft_pkg::result_type           result
);

   always_comb begin
      cft_pkg::parse_state_type st;
      cft_pkg::result_type      res;
      logic                     handled;
      logic                     add_req;
      logic [cft_pkg::BYTE_W-1:0] add_byte;
      logic                     is_term;

      st       = cur_state;
      res      = '0;
      handled  = 1'b0;
      add_req  = 1'b0;
      add_byte = char_byte;
      is_term  = (char_byte == cft_pkg::CH_NUL) || (char_byte == cft_pkg::CH_LF) ||
                 (char_byte == cft_pkg::CH_CR);

      if (line_start) begin
         st = '0;
      end else if (st.line_finished) begin
         handled = 1'b1;
      end

      // A quote held from the previous byte is either doubled or closes quotes.
      if (!handled && st.quote_pending) begin
         st.quote_pending = 1'b0;
         if (char_byte == cft_pkg::CH_QUOTE) begin
            add_req = 1'b1;
            handled = 1'b1;
         end else begin
            st.quoted_mode = 1'b0;
         end
      end

      if (!handled) begin
         if (is_term) begin
            st.line_finished  = 1'b1;
            st.quoted_mode    = 1'b0;
            res.valid         = 1'b1;
            res.event_kind    = cft_pkg::KIND_FIELD_END;
            res.out_byte      = char_byte;
            res.row_end       = 1'b1;
            if (st.field_counter >= cft_pkg::ROW_LIMIT) begin
               res.field_number  = cft_pkg::LAST_FIELD;
               res.char_position = '0;
            end else begin
               res.field_number  = cft_pkg::FNUM_W'(st.field_counter);
               res.char_position = cft_pkg::POS_W'(st.field_length);
            end
         end else if (char_byte == cft_pkg::CH_QUOTE) begin
            if (st.quoted_mode) begin
               st.quote_pending = 1'b1;
            end else begin
               st.quoted_mode = 1'b1;
            end
         end else if (char_byte == cft_pkg::CH_COMMA && !st.quoted_mode) begin
            // Commas of dropped fields give no word.
            if (st.field_counter < cft_pkg::ROW_LIMIT) begin
               res.valid         = 1'b1;
               res.event_kind    = cft_pkg::KIND_FIELD_END;
               res.out_byte      = char_byte;
               res.field_number  = cft_pkg::FNUM_W'(st.field_counter);
               res.char_position = cft_pkg::POS_W'(st.field_length);
               st.field_counter  = st.field_counter + 1'b1;
               if (st.field_counter >= cft_pkg::ROW_LIMIT) begin
                  st.field_overflow = 1'b1;
               end
            end
            st.field_length = '0;
         end else begin
            add_req = 1'b1;
         end
      end

      if (add_req && (st.field_counter < cft_pkg::ROW_LIMIT) &&
          (st.field_length < cft_pkg::LEN_LIMIT)) begin
         res.valid         = 1'b1;
         res.event_kind    = cft_pkg::KIND_CHAR;
         res.out_byte      = add_byte;
         res.field_number  = cft_pkg::FNUM_W'(st.field_counter);
         res.char_position = cft_pkg::POS_W'(st.field_length);
         st.field_length   = st.field_length + 1'b1;
      end

      res.too_many_fields = st.field_overflow;
      next_state = st;
      result     = res;
   end

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// CSV field tokenizer testbench
// Feeds CSV lines, noise and broken rows one byte per word through the
// tokenizer. A scoreboard keeps its own parse state, predicts every
// character and field-end word, and checks each output word in order. The
// sender bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic                       kind;
   logic [cft_pkg::BYTE_W-1:0] byte_val;
   logic [cft_pkg::FNUM_W-1:0] field_num;
   logic [cft_pkg::POS_W-1:0]  position;
   logic                       row_end;
   logic                       overflow;
} token_word_type;

class csv_token_scoreboard;
   bit             quote_open;
   bit             quote_held;
   bit             row_done;
   bit             fields_overflowed;
   int unsigned    chars_in_field;
   int unsigned    field_idx;
   token_word_type expected_tokens[$];
   int unsigned    bytes_handled;
   int unsigned    words_checked;
   int unsigned    error_count;

   function new();
      clear_row();
      row_done = 1'b1;
   endfunction

   function void clear_row();
      quote_open        = 1'b0;
      quote_held        = 1'b0;
      chars_in_field    = 0;
      field_idx         = 0;
      fields_overflowed = 1'b0;
   endfunction

   function int unsigned pending();
      return expected_tokens.size();
   endfunction

   // Characters of a dropped field or past the length limit give no word.
   function void append_char(logic [cft_pkg::BYTE_W-1:0] ch);
      token_word_type w;
      if (field_idx >= cft_pkg::MAX_ROW_FIELDS ||
          chars_in_field >= cft_pkg::MAX_FIELD_CHARS - 1) return;
      w.kind      = cft_pkg::KIND_CHAR;
      w.byte_val  = ch;
      w.field_num = cft_pkg::FNUM_W'(field_idx);
      w.position  = cft_pkg::POS_W'(chars_in_field);
      w.row_end   = 1'b0;
      w.overflow  = fields_overflowed;
      expected_tokens.push_back(w);
      chars_in_field++;
   endfunction

   function void note_byte(logic line_start, logic [cft_pkg::BYTE_W-1:0] ch);
      token_word_type w;
      int unsigned    idx;
      if (line_start) begin
         clear_row();
         row_done = 1'b0;
      end else if (row_done) begin
         return;
      end
      bytes_handled++;

      // A quote inside quotes waits one byte to see if it is doubled.
      if (quote_held) begin
         quote_held = 1'b0;
         if (ch == cft_pkg::CH_QUOTE) begin
            append_char(cft_pkg::CH_QUOTE);
            return;
         end
         quote_open = 1'b0;
      end

      if (ch == cft_pkg::CH_NUL || ch == cft_pkg::CH_LF || ch == cft_pkg::CH_CR) begin
         row_done   = 1'b1;
         quote_open = 1'b0;
         w.kind     = cft_pkg::KIND_FIELD_END;
         w.byte_val = ch;
         w.row_end  = 1'b1;
         w.overflow = fields_overflowed;
         if (field_idx >= cft_pkg::MAX_ROW_FIELDS) begin
            w.field_num = cft_pkg::LAST_FIELD;
            w.position  = '0;
         end else begin
            w.field_num = cft_pkg::FNUM_W'(field_idx);
            w.position  = cft_pkg::POS_W'(chars_in_field);
         end
         expected_tokens.push_back(w);
         return;
      end

      if (ch == cft_pkg::CH_QUOTE) begin
         if (quote_open) quote_held = 1'b1;
         else quote_open = 1'b1;
         return;
      end

      if (ch == cft_pkg::CH_COMMA && !quote_open) begin
         idx            = field_idx;
         w.position     = cft_pkg::POS_W'(chars_in_field);
         chars_in_field = 0;
         if (idx >= cft_pkg::MAX_ROW_FIELDS) return;
         field_idx = idx + 1;
         if (field_idx >= cft_pkg::MAX_ROW_FIELDS) fields_overflowed = 1'b1;
         w.kind      = cft_pkg::KIND_FIELD_END;
         w.byte_val  = ch;
         w.field_num = cft_pkg::FNUM_W'(idx);
         w.row_end   = 1'b0;
         w.overflow  = fields_overflowed;
         expected_tokens.push_back(w);
         return;
      end

      append_char(ch);
   endfunction

   task report_error(input string what);
      if (error_count < 200) $display("ERROR: %s", what);
      error_count++;
   endtask

   task check_token(input token_word_type got);
      token_word_type want;
      words_checked++;
      if (expected_tokens.size() == 0) begin
         report_error($sformatf("word %0d arrived with none expected: kind %0d byte %02h",
                                words_checked, got.kind, got.byte_val));
         return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind)
         report_error($sformatf("word %0d: event_kind %0d, expected %0d",
                                words_checked, got.kind, want.kind));
      if (got.byte_val !== want.byte_val)
         report_error($sformatf("word %0d: out_byte %02h, expected %02h",
                                words_checked, got.byte_val, want.byte_val));
      if (got.field_num !== want.field_num)
         report_error($sformatf("word %0d: field_number %0d, expected %0d",
                                words_checked, got.field_num, want.field_num));
      if (got.position !== want.position)
         report_error($sformatf("word %0d: char_position %0d, expected %0d",
                                words_checked, got.position, want.position));
      if (got.row_end !== want.row_end)
         report_error($sformatf("word %0d: row_end %0d, expected %0d",
                                words_checked, got.row_end, want.row_end));
      if (got.overflow !== want.overflow)
         report_error($sformatf("word %0d: too_many_fields %0d, expected %0d",
                                words_checked, got.overflow, want.overflow));
   endtask
endclass

module tb;

   localparam int unsigned ITEM_TARGET = 1050;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned SETTLE      = 8;

   typedef enum {ROW_LONG_FIELD, ROW_MANY_FIELDS, ROW_NOISE, ROW_PLAIN} row_shape_type;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic                       req_line_start = 1'b0;
   logic [cft_pkg::BYTE_W-1:0] req_char_byte  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic                       rsp_event_kind;
   logic [cft_pkg::BYTE_W-1:0] rsp_out_byte;
   logic [cft_pkg::FNUM_W-1:0] rsp_field_number;
   logic [cft_pkg::POS_W-1:0]  rsp_char_position;
   logic                       rsp_row_end;
   logic                       rsp_too_many_fields;

   token_word_type      rsp_word;
   csv_token_scoreboard sb;
   int unsigned         cycle_count = 0;
   int unsigned         burst_left  = 0;
   logic                at_line_start = 1'b0;
   bit                  hold_done   = 1'b0;

   csv_field_tokenizer DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_line_start      (req_line_start),
      .req_char_byte       (req_char_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_field_number    (rsp_field_number),
      .rsp_char_position   (rsp_char_position),
      .rsp_row_end         (rsp_row_end),
      .rsp_too_many_fields (rsp_too_many_fields)
   );

   assign rsp_word = {rsp_event_kind, rsp_out_byte, rsp_field_number, rsp_char_position,
                      rsp_row_end, rsp_too_many_fields};

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("csv_field_tokenizer test failed");
         $finish;
      end
   end

   // Output words are checked before the input word of the same edge is noted;
   // a result is registered and so always comes out after its byte is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_token(rsp_word);
         if (req_valid && req_ready) sb.note_byte(req_line_start, req_char_byte);
      end
   end

   // Receiver: segments of steady, patchy and mostly stalled ready, with one
   // long hold-off once traffic is flowing so the input side backs up.
   initial begin : receiver
      int unsigned mode;
      int unsigned seg_len;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && sb.words_checked >= 200) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode    = $urandom_range(0, 3);
         seg_len = $urandom_range(8, 60);
         repeat (seg_len) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 1) == 1);
               default: rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic push_byte(input logic ls, input logic [cft_pkg::BYTE_W-1:0] ch);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_line_start <= ls;
      req_char_byte  <= ch;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic put_line_byte(input logic [cft_pkg::BYTE_W-1:0] ch);
      push_byte(at_line_start, ch);
      at_line_start = 1'b0;
   endtask

   // Sender pauses until every predicted word has come out.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      @(posedge clock);
   endtask

   // A byte that is part of a field: never a terminator, quote or comma.
   function automatic logic [cft_pkg::BYTE_W-1:0] text_byte();
      int unsigned v;
      case ($urandom_range(0, 9))
         0: v = $urandom_range(128, 255);
         1: begin
            v = $urandom_range(1, 31);
            if (v == cft_pkg::CH_LF || v == cft_pkg::CH_CR) v = v + 1;
         end
         default: begin
            v = $urandom_range(32, 126);
            if (v == cft_pkg::CH_QUOTE || v == cft_pkg::CH_COMMA) v = v + 1;
         end
      endcase
      return v[cft_pkg::BYTE_W-1:0];
   endfunction

   task automatic gen_field(input bit quoted, input int unsigned len);
      if (quoted) begin
         put_line_byte(cft_pkg::CH_QUOTE);
         repeat (len) begin
            case ($urandom_range(0, 9))
               0: begin
                  put_line_byte(cft_pkg::CH_QUOTE);
                  put_line_byte(cft_pkg::CH_QUOTE);
               end
               1: put_line_byte(cft_pkg::CH_COMMA);
               default: put_line_byte(text_byte());
            endcase
         end
         put_line_byte(cft_pkg::CH_QUOTE);
         // A stray character after the closing quote drops out of quoted mode.
         if ($urandom_range(0, 7) == 0) put_line_byte(text_byte());
      end else begin
         repeat (len) put_line_byte(text_byte());
      end
   endtask

   task automatic gen_row(input row_shape_type shape);
      int unsigned nf;
      at_line_start = 1'b1;
      case (shape)
         ROW_LONG_FIELD: begin
            gen_field(1'b1, 270);
            put_line_byte(cft_pkg::CH_COMMA);
            gen_field(1'b0, 2);
         end
         ROW_MANY_FIELDS: begin
            nf = $urandom_range(62, 70);
            repeat (nf) begin
               gen_field($urandom_range(0, 3) == 0, $urandom_range(0, 2));
               put_line_byte(cft_pkg::CH_COMMA);
            end
            gen_field(1'b0, $urandom_range(0, 3));
         end
         ROW_NOISE: begin
            repeat ($urandom_range(1, 12))
               push_byte($urandom_range(0, 7) == 0,
                         cft_pkg::BYTE_W'($urandom_range(0, 255)));
            return;
         end
         default: begin
            nf = $urandom_range(1, 6);
            for (int i = 0; i < nf; i++) begin
               if (i != 0) put_line_byte(cft_pkg::CH_COMMA);
               gen_field($urandom_range(0, 2) == 0, $urandom_range(0, 8));
            end
         end
      endcase
      // Now and then a row is cut short and the next line start breaks in.
      if ($urandom_range(0, 19) == 0) return;
      case ($urandom_range(0, 2))
         0: put_line_byte(cft_pkg::CH_LF);
         1: put_line_byte(cft_pkg::CH_CR);
         default: put_line_byte(cft_pkg::CH_NUL);
      endcase
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3))
            put_line_byte(($urandom_range(0, 1) == 0) ? cft_pkg::CH_LF : text_byte());
   endtask

   initial begin
      int unsigned k;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: bytes before any line start, quoting rules, all terminators.
      push_byte(1'b0, "a");
      push_byte(1'b1, "a");
      push_byte(1'b0, cft_pkg::CH_COMMA);
      push_byte(1'b0, cft_pkg::CH_QUOTE);
      push_byte(1'b0, cft_pkg::CH_COMMA);
      push_byte(1'b0, cft_pkg::CH_QUOTE);
      push_byte(1'b0, cft_pkg::CH_QUOTE);
      push_byte(1'b0, cft_pkg::CH_QUOTE);
      push_byte(1'b0, 8'hFF);
      push_byte(1'b0, cft_pkg::CH_COMMA);
      push_byte(1'b0, cft_pkg::CH_LF);
      push_byte(1'b0, cft_pkg::CH_COMMA);
      push_byte(1'b1, cft_pkg::CH_QUOTE);
      push_byte(1'b0, cft_pkg::CH_QUOTE);
      push_byte(1'b1, "b");
      push_byte(1'b0, cft_pkg::CH_QUOTE);
      push_byte(1'b0, "c");
      push_byte(1'b0, cft_pkg::CH_QUOTE);
      push_byte(1'b0, cft_pkg::CH_CR);
      push_byte(1'b1, cft_pkg::CH_QUOTE);
      push_byte(1'b0, cft_pkg::CH_NUL);
      push_byte(1'b1, cft_pkg::CH_NUL);
      push_byte(1'b1, cft_pkg::CH_COMMA);
      push_byte(1'b0, cft_pkg::CH_LF);
      drain_results();

      gen_row(ROW_LONG_FIELD);
      gen_row(ROW_MANY_FIELDS);
      while (sb.bytes_handled < ITEM_TARGET) begin
         k = $urandom_range(0, 99);
         if (k < 3) gen_row(ROW_LONG_FIELD);
         else if (k < 6) gen_row(ROW_MANY_FIELDS);
         else if (k < 12) gen_row(ROW_NOISE);
         else gen_row(ROW_PLAIN);
         if ($urandom_range(0, 29) == 0) drain_results();
      end
      drain_results();
      repeat (SETTLE) @(posedge clock);

      if (sb.error_count == 0) begin
         $display("csv_field_tokenizer test passed");
      end else begin
         $display("csv_field_tokenizer test failed");
      end
      $finish;
   end

endmodule

/* files.f */
src/cft_pkg.sv
src/cft_parser.sv
src/csv_field_tokenizer.sv
tb/tb.sv
